@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the segment/triangle test block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define RTSV_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define RTSV_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/rtsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rtsv_pkg
// Shared constants and types for the segment/triangle signed volume test.
// ----------------------------------------------------------------------------
package rtsv_pkg;

    // Coordinate format and segment extension defaults
    localparam int COORD_BITS    = 24;
    localparam int FRAC_BITS     = 8;
    localparam int EXTEND_LENGTH = 1000;

    // Configuration register map
    localparam int NUM_REGS     = 6;
    localparam int REG_IDX_BITS = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SEG_A_X = 3'd0,
        REG_SEG_A_Y = 3'd1,
        REG_SEG_A_Z = 3'd2,
        REG_SEG_B_X = 3'd3,
        REG_SEG_B_Y = 3'd4,
        REG_SEG_B_Z = 3'd5
    } reg_idx_t;

    // Valid pipe depth from accept to the final compare stage
    localparam int PIPE_DEPTH = 7;

    // Sign of a volume: negative flag and nonzero flag
    typedef struct packed {
        logic neg;
        logic nz;
    } vsign_t;

endpackage

@@ hw/rtl/rtsv_far.sv @@
// ----------------------------------------------------------------------------
// rtsv_far
// Segment registers and far point sequencer: squares, bit-serial square root
// and one restoring division per axis, one bit per cycle.
// ----------------------------------------------------------------------------
module rtsv_far #(
    parameter int COORD_BITS    = rtsv_pkg::COORD_BITS,
    parameter int FRAC_BITS     = rtsv_pkg::FRAC_BITS,
    parameter int EXTEND_LENGTH = rtsv_pkg::EXTEND_LENGTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [rtsv_pkg::REG_IDX_BITS-1:0]   wr_index,
    input  logic [COORD_BITS-1:0]               wr_data,
    output logic                                busy,
    output logic                                degenerate,
    output logic signed [COORD_BITS+1:0]        far_a [3],
    output logic signed [COORD_BITS+1:0]        far_b [3]
);

    localparam int MW  = COORD_BITS + 1;
    localparam int L2W = 2 * MW + 2;
    localparam int LW  = L2W / 2;
    localparam int EB  = $clog2(EXTEND_LENGTH + 1);
    localparam int SW  = EB + FRAC_BITS;
    localparam int QW  = SW + 1;
    localparam int NW  = MW + SW + 1;
    localparam int CNW = $clog2(NW);
    localparam int FW  = COORD_BITS + 2;
    localparam logic [SW-1:0] EXT_SCALED = SW'(EXTEND_LENGTH) << FRAC_BITS;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SQUARE = 5'b00010,
        ST_ROOT   = 5'b00100,
        ST_LOAD   = 5'b01000,
        ST_DIVIDE = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             axis_reg, axis_next;
    logic signed [COORD_BITS-1:0] seg_reg [6];
    logic signed [COORD_BITS-1:0] seg_next [6];
    logic signed [FW-1:0]   far_a_reg [3], far_a_next [3];
    logic signed [FW-1:0]   far_b_reg [3], far_b_next [3];
    logic [L2W-1:0]         len2_reg, len2_next;
    logic [L2W-1:0]         xrem_reg, xrem_next;
    logic [L2W-1:0]         root_reg, root_next;
    logic [L2W-1:0]         bit_reg, bit_next;
    logic [LW-1:0]          len_reg, len_next;
    logic [NW-1:0]          num_reg, num_next;
    logic [LW-1:0]          rem_reg, rem_next;
    logic [CNW-1:0]         cnt_reg, cnt_next;

    logic signed [MW-1:0]   diff [3];
    logic [MW-1:0]          mag [3];
    logic [2*MW-1:0]        sq;
    logic [NW-2:0]          scaled;
    logic [L2W-1:0]         trial;
    logic [LW:0]            rem_sh;
    logic                   ge;
    logic signed [FW-1:0]   off;
    logic [2:0]             idx_b;

    // Endpoint differences and magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = MW'(seg_reg[i]) - MW'(seg_reg[i+3]);
            mag[i]  = diff[i][MW-1] ? $unsigned(-diff[i]) : $unsigned(diff[i]);
        end
    end

    assign degenerate = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
    assign busy       = (state_reg != ST_IDLE);
    assign sq         = mag[axis_reg] * mag[axis_reg];
    assign scaled     = mag[axis_reg] * EXT_SCALED;
    assign trial      = root_reg + bit_reg;
    assign rem_sh     = {rem_reg, num_reg[NW-1]};
    assign ge         = (rem_sh >= {1'b0, len_reg});
    assign idx_b      = 3'(axis_reg) + 3'(rtsv_pkg::REG_SEG_B_X);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        seg_next   = seg_reg;
        far_a_next = far_a_reg;
        far_b_next = far_b_reg;
        len2_next  = len2_reg;
        xrem_next  = xrem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        len_next   = len_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        off        = '0;

        case (state_reg)
            ST_IDLE:
            begin
            end
            // Sum of squared differences, one axis a cycle
            ST_SQUARE:
            begin
                len2_next = len2_reg + L2W'(sq);
                if (axis_reg == 2'd2)
                begin
                    axis_next = 2'd0;
                    if (degenerate)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            far_a_next[i] = FW'(seg_reg[i]);
                            far_b_next[i] = FW'(seg_reg[i+3]);
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        xrem_next  = len2_next;
                        root_next  = '0;
                        bit_next   = L2W'(1) << (L2W - 2);
                        state_next = ST_ROOT;
                    end
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            // Floor square root, one result bit a cycle
            ST_ROOT:
            begin
                if (xrem_reg >= trial)
                begin
                    xrem_next = xrem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    len_next   = LW'(root_next);
                    state_next = ST_LOAD;
                end
            end
            // Rounded numerator for this axis
            ST_LOAD:
            begin
                num_next   = NW'(scaled) + NW'(len_reg >> 1);
                rem_next   = '0;
                cnt_next   = CNW'(NW - 1);
                state_next = ST_DIVIDE;
            end
            // Restoring division, quotient shifts into the numerator
            ST_DIVIDE:
            begin
                rem_next = ge ? LW'(rem_sh - {1'b0, len_reg}) : LW'(rem_sh);
                num_next = {num_reg[NW-2:0], ge};
                if (cnt_reg == '0)
                begin
                    off = diff[axis_reg][MW-1] ? -FW'(num_next[QW-1:0])
                                               : FW'(num_next[QW-1:0]);
                    far_a_next[axis_reg] = FW'(seg_reg[axis_reg]) + off;
                    far_b_next[axis_reg] = FW'(seg_reg[idx_b]) - off;
                    if (axis_reg == 2'd2)
                    begin
                        axis_next  = 2'd0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CNW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register write restarts the sequence
        if (wr_en && (wr_index < 3'(rtsv_pkg::NUM_REGS)))
        begin
            seg_next[wr_index] = wr_data;
            state_next         = ST_SQUARE;
            axis_next          = 2'd0;
            len2_next          = '0;
        end
    end

    // Control state, segment and far points
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
            for (int i = 0; i < 6; i++)
            begin
                seg_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                far_a_reg[i] <= '0;
                far_b_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            seg_reg   <= seg_next;
            far_a_reg <= far_a_next;
            far_b_reg <= far_b_next;
        end
    end

    // Arithmetic working registers
    always_ff @(posedge clk)
    begin
        len2_reg <= len2_next;
        xrem_reg <= xrem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        len_reg  <= len_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign far_a = far_a_reg;
    assign far_b = far_b_reg;

endmodule

@@ hw/rtl/rtsv_vol.sv @@
// ----------------------------------------------------------------------------
// rtsv_vol
// Six-stage pipeline giving the sign of ((b-a) x (c-a)) . (d-a), exact.
// ----------------------------------------------------------------------------
module rtsv_vol #(
    parameter int FW = rtsv_pkg::COORD_BITS + 2
) (
    input  logic                 clk,
    input  logic signed [FW-1:0] pa [3],
    input  logic signed [FW-1:0] pb [3],
    input  logic signed [FW-1:0] pc [3],
    input  logic signed [FW-1:0] pd [3],
    output rtsv_pkg::vsign_t     sign
);

    localparam int DW  = FW + 1;
    localparam int PW  = 2 * DW;
    localparam int CW  = PW + 1;
    localparam int PLW = 2 * DW + 1;
    localparam int TW  = 3 * DW + 3;

    logic signed [DW-1:0]  u_reg [3], v_reg [3], w_reg [3];
    logic signed [DW-1:0]  u_next [3], v_next [3], w_next [3];
    logic signed [PW-1:0]  prod_reg [6], prod_next [6];
    logic signed [DW-1:0]  w1_reg [3];
    logic signed [CW-1:0]  cross_reg [3], cross_next [3];
    logic signed [DW-1:0]  w2_reg [3];
    logic signed [PLW-1:0] pl_reg [3], pl_next [3];
    logic signed [PLW-1:0] ph_reg [3], ph_next [3];
    logic signed [TW-1:0]  term_reg [3], term_next [3];
    logic signed [TW-1:0]  sum;
    rtsv_pkg::vsign_t      sign_reg, sign_next;

    always_comb
    begin
        // Edge vectors
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = DW'(pb[i]) - DW'(pa[i]);
            v_next[i] = DW'(pc[i]) - DW'(pa[i]);
            w_next[i] = DW'(pd[i]) - DW'(pa[i]);
        end
        // Cross product partial terms
        prod_next[0] = u_reg[1] * v_reg[2];
        prod_next[1] = u_reg[2] * v_reg[1];
        prod_next[2] = u_reg[2] * v_reg[0];
        prod_next[3] = u_reg[0] * v_reg[2];
        prod_next[4] = u_reg[0] * v_reg[1];
        prod_next[5] = u_reg[1] * v_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            // Cross product components
            cross_next[i] = CW'(prod_reg[2*i]) - CW'(prod_reg[2*i+1]);
            // Dot product split into low (unsigned) and high (signed) halves
            pl_next[i] = $signed({1'b0, cross_reg[i][DW-1:0]}) * w2_reg[i];
            ph_next[i] = $signed(cross_reg[i][CW-1:DW]) * w2_reg[i];
            term_next[i] = (TW'(ph_reg[i]) <<< DW) + TW'(pl_reg[i]);
        end
        // Final sum and sign
        sum            = term_reg[0] + term_reg[1] + term_reg[2];
        sign_next.neg  = sum[TW-1];
        sign_next.nz   = |sum;
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
        prod_reg  <= prod_next;
        w1_reg    <= w_reg;
        cross_reg <= cross_next;
        w2_reg    <= w1_reg;
        pl_reg    <= pl_next;
        ph_reg    <= ph_next;
        term_reg  <= term_next;
        sign_reg  <= sign_next;
    end

    assign sign = sign_reg;

endmodule

@@ hw/rtl/ray_triangle_signed_volume_test_top.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_signed_volume_test_top: one triangle per cycle while busy is
// low; done strobes after vertex capture, the six-stage volume pipeline
// and the done register. A register write keeps busy high while the
// far point sequencer runs its squares, bit-serial root and divider.
// Reset clears pipe valids, segment and far points to zero.
// ----------------------------------------------------------------------------
module ray_triangle_signed_volume_test_top #(
    parameter int COORD_BITS    = rtsv_pkg::COORD_BITS,
    parameter int FRAC_BITS     = rtsv_pkg::FRAC_BITS,
    parameter int EXTEND_LENGTH = rtsv_pkg::EXTEND_LENGTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic                              wr_en,
    input  logic [rtsv_pkg::REG_IDX_BITS-1:0] wr_index,
    input  logic [COORD_BITS-1:0]             wr_data,
    input  logic signed [COORD_BITS-1:0]      v0_x,
    input  logic signed [COORD_BITS-1:0]      v0_y,
    input  logic signed [COORD_BITS-1:0]      v0_z,
    input  logic signed [COORD_BITS-1:0]      v1_x,
    input  logic signed [COORD_BITS-1:0]      v1_y,
    input  logic signed [COORD_BITS-1:0]      v1_z,
    input  logic signed [COORD_BITS-1:0]      v2_x,
    input  logic signed [COORD_BITS-1:0]      v2_y,
    input  logic signed [COORD_BITS-1:0]      v2_z,
    output logic                              hit,
    output logic                              degenerate_ray
);

    localparam int FW    = COORD_BITS + 2;
    localparam int DEPTH = rtsv_pkg::PIPE_DEPTH;

    logic                          accept;
    logic                          seg_deg;
    logic signed [FW-1:0]          far_a [3], far_b [3];
    logic signed [COORD_BITS-1:0]  vert_reg [9];
    logic signed [FW-1:0]          p1 [3], p2 [3], p3 [3];
    logic                          vld_reg [DEPTH];
    logic                          deg_reg [DEPTH];
    rtsv_pkg::vsign_t              s1, s2, e1, e2, e3;
    logic                          done_reg, done_next;
    logic                          hit_reg, hit_next;
    logic                          dout_reg;

    assign accept = start && !busy;

    // Segment registers and far point sequencer
    rtsv_far #(
        .COORD_BITS    (COORD_BITS),
        .FRAC_BITS     (FRAC_BITS),
        .EXTEND_LENGTH (EXTEND_LENGTH)
    ) u_far (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .busy       (busy),
        .degenerate (seg_deg),
        .far_a      (far_a),
        .far_b      (far_b)
    );

    // Vertex capture on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vert_reg[0] <= v0_x;
            vert_reg[1] <= v0_y;
            vert_reg[2] <= v0_z;
            vert_reg[3] <= v1_x;
            vert_reg[4] <= v1_y;
            vert_reg[5] <= v1_z;
            vert_reg[6] <= v2_x;
            vert_reg[7] <= v2_y;
            vert_reg[8] <= v2_z;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1[i] = FW'(vert_reg[i]);
            p2[i] = FW'(vert_reg[3+i]);
            p3[i] = FW'(vert_reg[6+i]);
        end
    end

    // Five volume pipelines
    rtsv_vol #(.FW(FW)) u_vol_s1 (.clk(clk), .pa(far_a), .pb(p1), .pc(p2), .pd(p3), .sign(s1));
    rtsv_vol #(.FW(FW)) u_vol_s2 (.clk(clk), .pa(far_b), .pb(p1), .pc(p2), .pd(p3), .sign(s2));
    rtsv_vol #(.FW(FW)) u_vol_e1 (.clk(clk), .pa(far_a), .pb(far_b), .pc(p1), .pd(p2), .sign(e1));
    rtsv_vol #(.FW(FW)) u_vol_e2 (.clk(clk), .pa(far_a), .pb(far_b), .pc(p2), .pd(p3), .sign(e2));
    rtsv_vol #(.FW(FW)) u_vol_e3 (.clk(clk), .pa(far_a), .pb(far_b), .pc(p3), .pd(p1), .sign(e3));

    // Valid and degenerate flags travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg[0] <= seg_deg;
        for (int i = 1; i < DEPTH; i++)
        begin
            deg_reg[i] <= deg_reg[i-1];
        end
        hit_reg  <= hit_next;
        dout_reg <= deg_reg[DEPTH-1];
    end

    // Crossing decision
    assign done_next = vld_reg[DEPTH-1];
    assign hit_next  = !deg_reg[DEPTH-1] && (s1 != s2) && (e1 == e2) && (e2 == e3);

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign degenerate_ray = dout_reg;

endmodule

@@ hw/rtl/rtsv_checker.sv @@
// ----------------------------------------------------------------------------
// rtsv_checker
// Port-level timing checks for the segment/triangle test, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtsv_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic                              wr_en,
    input logic [rtsv_pkg::REG_IDX_BITS-1:0] wr_index,
    input logic                              hit,
    input logic                              degenerate_ray
);

    // Every transfer gives a result
    `RTSV_ASSERT(a_accept_done, clk, rst_n, (start && !busy) |-> ##(rtsv_pkg::PIPE_DEPTH + 1) done, "result missing after transfer")
    // No result without a matching earlier transfer
    `RTSV_ASSERT(a_done_src, clk, rst_n, done |-> $past(start && !busy, rtsv_pkg::PIPE_DEPTH + 1), "result without transfer")
    // Degenerate segment never hits
    `RTSV_ASSERT_ALWAYS(a_deg_no_hit, clk, (done && degenerate_ray) |-> !hit, "hit on degenerate segment")
    // A register write starts the far point sequence
    `RTSV_ASSERT(a_cfg_busy, clk, rst_n, (wr_en && (wr_index < 3'(rtsv_pkg::NUM_REGS))) |=> busy, "write did not start sequence")
    // Idle stays idle without a write
    `RTSV_ASSERT(a_idle_hold, clk, rst_n, (!busy && !wr_en) |=> !busy, "busy without write")

endmodule

bind ray_triangle_signed_volume_test_top rtsv_checker u_rtsv_checker (.*);
